@@ design/rsst_pkg.sv @@
// range sum segment tree: shared widths, request codes and walk flags
// no dependencies; imported by every module of the block
`default_nettype none

package rsst_pkg;

  localparam int PosW         = 10;
  localparam int ValW         = 32;
  localparam int NumLeavesDef = 1024;

  // request codes carried on action_i
  localparam logic ActSet   = 1'b0;
  localparam logic ActQuery = 1'b1;

  // decisions of the node stepping unit for the current node
  typedef struct packed {
    logic is_leaf;  // node covers a single leaf
    logic at_hi;    // target equals the node's high bound
    logic go_left;  // target lies in the left half
  } walk_flags_t;

endpackage

`default_nettype wire

@@ design/rsst_mem.sv @@
// range sum segment tree: node store, one write port and one registered read port
// uses rsst_pkg for the data width
`default_nettype none

module rsst_mem #(
  parameter int Depth = 4 * rsst_pkg::NumLeavesDef,
  parameter int AW    = $clog2(4 * rsst_pkg::NumLeavesDef)
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [AW-1:0]             waddr_i,
  input  wire logic [rsst_pkg::ValW-1:0] wdata_i,
  input  wire logic [AW-1:0]             raddr_i,
  output      logic [rsst_pkg::ValW-1:0] rdata_o
);
  import rsst_pkg::*;

  logic [ValW-1:0] mem_q [Depth];
  logic [ValW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/rsst_walk.sv @@
// range sum segment tree: node stepping unit (split point, child, parent, sibling)
// uses rsst_pkg for the walk flag struct
`default_nettype none

module rsst_walk #(
  parameter int LW = $clog2(rsst_pkg::NumLeavesDef),
  parameter int AW = $clog2(4 * rsst_pkg::NumLeavesDef)
) (
  input  wire logic [AW-1:0]       node_i,
  input  wire logic [LW-1:0]       lo_i,
  input  wire logic [LW-1:0]       hi_i,
  input  wire logic [LW-1:0]       tgt_i,
  output      logic [LW-1:0]       mid_o,
  output      logic [AW-1:0]       left_o,
  output      logic [AW-1:0]       right_o,
  output      logic [AW-1:0]       parent_o,
  output      logic [AW-1:0]       sibling_o,
  output      rsst_pkg::walk_flags_t flags_o
);
  import rsst_pkg::*;

  logic [LW:0]   span;
  logic [AW-1:0] node_m1;

  assign span  = {1'b0, lo_i} + {1'b0, hi_i};
  assign mid_o = span[LW:1];

  assign left_o  = {node_i[AW-2:0], 1'b1};
  assign right_o = {node_i[AW-2:0], 1'b0} + AW'(2);

  assign node_m1   = node_i - AW'(1);
  assign parent_o  = {1'b0, node_m1[AW-1:1]};
  // odd nodes are left children
  assign sibling_o = node_i[0] ? (node_i + AW'(1)) : node_m1;

  assign flags_o.is_leaf = (lo_i == hi_i);
  assign flags_o.at_hi   = (tgt_i == hi_i);
  assign flags_o.go_left = (tgt_i <= mid_o);

endmodule

`default_nettype wire

@@ design/range_sum_segment_tree_unit.sv @@
// range sum segment tree: top level with sequencer, shared adder and result register
// uses rsst_pkg, rsst_walk and rsst_mem
//
//  channel  | ports                                          | handshake
//  ---------+------------------------------------------------+------------------------------
//  request  | action_i position_i range_end_i value_i        | taken when start_i && !busy_o
//  result   | sum_o                                          | one cycle with sum_valid_o
//
// after reset a clearing pass zeroes the store, with busy_o high.
// a set request steps down one level at a time to the leaf and writes it, then for each
// level going up it reads the sibling and writes the parent.
// a query runs a prefix walk up to the range end and, if position_i is nonzero, a second walk
// subtracting the prefix below it, with at most one store read per level, into a registered sum_o.
// an empty range or a set past the last leaf is handled in idle; results are never held off.
`default_nettype none

module range_sum_segment_tree_unit #(
  parameter int NUM_LEAVES = rsst_pkg::NumLeavesDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output      logic                             busy_o,
  input  wire logic                             action_i,
  input  wire logic [rsst_pkg::PosW-1:0]        position_i,
  input  wire logic [rsst_pkg::PosW-1:0]        range_end_i,
  input  wire logic signed [rsst_pkg::ValW-1:0] value_i,
  output      logic                             sum_valid_o,
  output      logic signed [rsst_pkg::ValW-1:0] sum_o
);
  import rsst_pkg::*;

  localparam int TreeDepth = 4 * NUM_LEAVES;
  localparam int AW        = $clog2(TreeDepth);
  localparam int LW        = $clog2(NUM_LEAVES);
  localparam int CW        = (LW > PosW) ? LW : PosW;

  localparam logic [LW-1:0] LastLeaf = LW'(NUM_LEAVES - 1);
  localparam logic [CW-1:0] LastExt  = CW'(NUM_LEAVES - 1);
  localparam logic [AW-1:0] ClrLast  = AW'(TreeDepth - 1);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_DOWN  = 8'b0000_0100,
    S_SIB   = 8'b0000_1000,
    S_UP    = 8'b0001_0000,
    S_WALK  = 8'b0010_0000,
    S_LAST  = 8'b0100_0000
  } state_e;

  state_e          state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic            pend_q, pend_d;
  logic            pass_q, pass_d;
  logic            has_low_q, has_low_d;
  logic            sum_valid_q, sum_valid_d;
  logic [AW-1:0]   node_q, node_d;
  logic [LW-1:0]   lo_q, lo_d;
  logic [LW-1:0]   hi_q, hi_d;
  logic [LW-1:0]   tgt_q, tgt_d;
  logic [LW-1:0]   low_q, low_d;
  logic [ValW-1:0] acc_q, acc_d;
  logic [ValW-1:0] val_q, val_d;
  logic [ValW-1:0] sum_q, sum_d;

  logic [CW-1:0]   pos_ext, end_ext, end_clamp;
  logic [LW-1:0]   mid;
  logic [AW-1:0]   left, right, parent, sibling;
  walk_flags_t     flags;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [ValW-1:0] mem_wdata, mem_rdata;
  logic [ValW-1:0] alu_res;

  rsst_walk #(
    .LW(LW),
    .AW(AW)
  ) u_walk (
    .node_i   (node_q),
    .lo_i     (lo_q),
    .hi_i     (hi_q),
    .tgt_i    (tgt_q),
    .mid_o    (mid),
    .left_o   (left),
    .right_o  (right),
    .parent_o (parent),
    .sibling_o(sibling),
    .flags_o  (flags)
  );

  rsst_mem #(
    .Depth(TreeDepth),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // shared adder: sums on the way up and in the first prefix walk,
  // subtracts during the walk for the prefix below the low end
  assign alu_res = pass_q ? (acc_q - mem_rdata) : (acc_q + mem_rdata);

  assign pos_ext   = CW'(position_i);
  assign end_ext   = CW'(range_end_i);
  assign end_clamp = (end_ext > LastExt) ? LastExt : end_ext;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pend_d      = 1'b0;
    pass_d      = pass_q;
    has_low_d   = has_low_q;
    sum_valid_d = 1'b0;
    node_d      = node_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    tgt_d       = tgt_q;
    low_d       = low_q;
    acc_d       = acc_q;
    val_d       = val_q;
    sum_d       = sum_q;
    mem_we      = 1'b0;
    mem_waddr   = node_q;
    mem_wdata   = alu_res;
    mem_raddr   = node_q;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == ClrLast) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          node_d = '0;
          lo_d   = '0;
          hi_d   = LastLeaf;
          acc_d  = '0;
          val_d  = value_i;
          pass_d = 1'b0;
          if (action_i == ActSet) begin
            // a set past the last leaf leaves the store alone
            if (pos_ext <= LastExt) begin
              tgt_d   = LW'(pos_ext);
              state_d = S_DOWN;
            end
          end else begin
            if (pos_ext > end_clamp) begin
              sum_d       = '0;
              sum_valid_d = 1'b1;
            end else begin
              tgt_d     = LW'(end_clamp);
              has_low_d = (pos_ext != '0);
              low_d     = LW'(pos_ext - CW'(1));
              state_d   = S_WALK;
            end
          end
        end
      end
      S_DOWN: begin
        if (flags.is_leaf) begin
          mem_we    = 1'b1;
          mem_waddr = node_q;
          mem_wdata = val_q;
          acc_d     = val_q;
          state_d   = (node_q == '0) ? S_IDLE : S_SIB;
        end else if (flags.go_left) begin
          node_d = left;
          hi_d   = mid;
        end else begin
          node_d = right;
          lo_d   = mid + LW'(1);
        end
      end
      S_SIB: begin
        mem_raddr = sibling;
        state_d   = S_UP;
      end
      S_UP: begin
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = alu_res;
        acc_d     = alu_res;
        node_d    = parent;
        state_d   = (parent == '0) ? S_IDLE : S_SIB;
      end
      S_WALK: begin
        // fold in the read issued in the previous cycle
        if (pend_q) begin
          acc_d = alu_res;
        end
        if (flags.at_hi) begin
          mem_raddr = node_q;
          pend_d    = 1'b1;
          state_d   = S_LAST;
        end else if (flags.go_left) begin
          node_d = left;
          hi_d   = mid;
        end else begin
          // whole left child lies inside the prefix
          mem_raddr = left;
          pend_d    = 1'b1;
          node_d    = right;
          lo_d      = mid + LW'(1);
        end
      end
      S_LAST: begin
        if (!pass_q && has_low_q) begin
          acc_d   = alu_res;
          pass_d  = 1'b1;
          tgt_d   = low_q;
          node_d  = '0;
          lo_d    = '0;
          hi_d    = LastLeaf;
          state_d = S_WALK;
        end else begin
          sum_d       = alu_res;
          sum_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      pass_q      <= 1'b0;
      has_low_q   <= 1'b0;
      sum_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      pass_q      <= pass_d;
      has_low_q   <= has_low_d;
      sum_valid_q <= sum_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    tgt_q  <= tgt_d;
    low_q  <= low_d;
    acc_q  <= acc_d;
    val_q  <= val_d;
    sum_q  <= sum_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign sum_valid_o = sum_valid_q;
  assign sum_o       = sum_q;

endmodule

`default_nettype wire
